### rtl/core/rfid_afd_pkg.sv
// Shared types, constants and helper functions of the RFID frame decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package rfid_afd_pkg;

    localparam int BIT_PERIOD_DEF = 256;
    localparam int MAX_DURATION   = 4095;
    localparam int FRAME_BITS     = 136;
    localparam int CHAR_START     = 39;
    localparam int CHAR_LEN       = 10;
    localparam int NUM_CHARS      = 9;
    localparam int CNT_W          = 8;
    localparam int PULSE_W        = 12;
    localparam int DUR_W          = 16;
    localparam int CARD_W         = 32;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 12'd60;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 12'd4000;

    localparam logic [CNT_W-1:0] PREAMBLE_BITS = 8'd8;
    localparam logic [CNT_W-1:0] LONG_LIMIT    = 8'd9;
    localparam logic [CNT_W-1:0] FRAME_CNT     = 8'd136;

    localparam logic [7:0] MARK_BYTE = 8'b11111111;
    localparam logic [7:0] STX_BYTE  = 8'b00000010;
    localparam logic [6:0] DATA_MASK = 7'h7F;

    // Register indexes of the configuration port.
    localparam logic REG_MIN_PULSE = 1'b0;
    localparam logic REG_MAX_PULSE = 1'b1;

    typedef struct packed {
        logic load_in;
        logic div_step;
        logic decide;
        logic shift;
        logic check;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic last_shift;
        logic match;
        logic out_free;
    } status_t;

    // Returns {valid, nibble} for an ASCII hex digit.
    function automatic logic [4:0] hex_value(input logic [6:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 7'h30 && c <= 7'h39) begin
            r = {1'b1, 4'(c - 7'h30)};
        end else if (c >= 7'h41 && c <= 7'h46) begin
            r = {1'b1, 4'(c - 7'h37)};
        end else if (c >= 7'h61 && c <= 7'h66) begin
            r = {1'b1, 4'(c - 7'h57)};
        end
        return r;
    endfunction

endpackage

### rtl/core/rfid_async_frame_decoder_top.sv
// Top level of the RFID asynchronous frame decoder: stream ports, APB register
// block, and the controller and datapath. Uses rfid_afd_pkg, rfid_afd_ctrl, rfid_afd_dp.
//
// Each input word carries one demodulated level and its duration in timer
// ticks. The block rounds the duration to a number of bit periods, shifts that
// many bits into a 136-bit frame register and, when the register holds a valid
// frame (marks, STX, nine odd-parity characters, XOR checksum, hex digits),
// sends out the 32-bit card number. Each word is accepted, then the rounding
// division is done (a multiply by a constant reciprocal), the bit count is
// decided, N bits are shifted in one per cycle, the frame is checked and the
// result is handed off. N is usually 1 to 8 and at most 16 at a 256-tick bit
// period (never more than 136 at shorter periods); words that are ignored or
// shift nothing end once the bit count is decided. A finished card number waits
// in an output register while the next word is already being decoded; the
// hand-off cycle stalls only while that register still holds an untaken word.
module rfid_async_frame_decoder_top
    import rfid_afd_pkg::*;
#(
    parameter int BIT_PERIOD = BIT_PERIOD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [0] level, [16:1] duration, [23:17] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // m_tdata: [31:0] card_number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [PULSE_W-1:0] min_pulse_reg;
    logic [PULSE_W-1:0] max_pulse_reg;
    logic               cfg_write;
    cmd_t               cmd;
    status_t            st;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_MIN_PULSE: min_pulse_reg <= pwdata[PULSE_W-1:0];
                REG_MAX_PULSE: max_pulse_reg <= pwdata[PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN_PULSE: prdata = 32'(min_pulse_reg);
            REG_MAX_PULSE: prdata = 32'(max_pulse_reg);
            default:       prdata = '0;
        endcase
    end

    rfid_afd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rfid_afd_dp #(
        .BIT_PERIOD (BIT_PERIOD)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .st          (st),
        .in_level    (s_tdata[0]),
        .in_duration (s_tdata[DUR_W:1]),
        .min_pulse   (min_pulse_reg),
        .max_pulse   (max_pulse_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_card    (m_tdata)
    );

endmodule

### rtl/core/rfid_afd_ctrl.sv
// Controller state machine of the RFID frame decoder: sequences input capture,
// rounding division, bit shifting, frame check and result hand-off. Uses rfid_afd_pkg.
module rfid_afd_ctrl
    import rfid_afd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = st.skip ? ST_IDLE : ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (st.last_shift) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!st.match) begin
                    state_next = ST_IDLE;
                end else if (st.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/rfid_afd_dp.sv
// Datapath of the RFID frame decoder: reciprocal-multiply rounding divider, preamble
// and polarity tracking, 136-bit frame shift register, frame check and result
// register. Driven by rfid_afd_ctrl through cmd_t; uses rfid_afd_pkg.
module rfid_afd_dp
    import rfid_afd_pkg::*;
#(
    parameter int BIT_PERIOD = BIT_PERIOD_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output status_t            st,
    input  logic               in_level,
    input  logic [DUR_W-1:0]   in_duration,
    input  logic [PULSE_W-1:0] min_pulse,
    input  logic [PULSE_W-1:0] max_pulse,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CARD_W-1:0]  out_card
);

    localparam int NW = $clog2(MAX_DURATION + 1 + BIT_PERIOD / 2);
    localparam int SH = NW + $clog2(BIT_PERIOD);
    localparam int MW = NW + 1;
    localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + BIT_PERIOD - 1) / BIT_PERIOD);

    logic                  level_reg;
    logic                  too_long_reg;
    logic                  above_min_reg;
    logic [NW-1:0]         num_reg;
    logic [NW-1:0]         quo_reg;
    logic                  pre_reg, pol_reg;
    logic [CNT_W-1:0]      shift_cnt_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic                  match_reg;
    logic [CARD_W-1:0]     card_reg;
    logic                  out_valid_reg;
    logic [CARD_W-1:0]     out_card_reg;

    logic [NW+MW-1:0]      prod;
    logic                  long_count;
    logic [CNT_W-1:0]      eff_count;
    logic                  match_next;
    logic [CARD_W-1:0]     card_next;

    // The rounded dividend is below 2^NW, so multiplying by the rounded-up scaled
    // reciprocal and dropping SH bits gives the exact integer quotient.
    assign prod = (NW+MW)'(num_reg) * (NW+MW)'(RECIP);

    assign long_count = quo_reg >= NW'(LONG_LIMIT);

    always_comb begin
        if (too_long_reg) begin
            eff_count = '0;
        end else if (long_count && !pre_reg) begin
            eff_count = PREAMBLE_BITS;
        end else if (long_count) begin
            eff_count = (quo_reg > NW'(FRAME_CNT)) ? FRAME_CNT : CNT_W'(quo_reg);
        end else if (quo_reg == '0 && above_min_reg) begin
            eff_count = CNT_W'(1);
        end else begin
            eff_count = CNT_W'(quo_reg);
        end
    end

    // Frame check of marks, bits 8-10, STX and characters; the ninth character is the XOR checksum of the first eight.
    always_comb begin
        logic [7:0] ch;
        logic [6:0] xsum;
        logic [4:0] hv;
        logic       ok;
        ok        = 1'b1;
        xsum      = '0;
        hv        = '0;
        card_next = '0;
        ok = ok && (frame_reg[7:0] == MARK_BYTE);
        ok = ok && !frame_reg[8] && !frame_reg[9] && frame_reg[10];
        for (int i = 0; i < 8; i++) begin
            ok = ok && (frame_reg[11 + i] == STX_BYTE[7 - i]);
            ok = ok && (frame_reg[128 + i] == MARK_BYTE[7 - i]);
        end
        for (int k = 0; k < NUM_CHARS; k++) begin
            ch = frame_reg[CHAR_START + CHAR_LEN * k +: 8];
            ok = ok && (^ch);
            if (k < NUM_CHARS - 1) begin
                xsum = xsum ^ (ch[6:0] & DATA_MASK);
                hv   = hex_value(ch[6:0]);
                ok   = ok && hv[4];
                card_next[CARD_W - 4 - 4 * k +: 4] = hv[3:0];
            end else begin
                ok = ok && ((ch[6:0] & DATA_MASK) == xsum);
            end
        end
        match_next = ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_reg       <= 1'b0;
            pol_reg       <= 1'b0;
            frame_reg     <= '0;
            shift_cnt_reg <= '0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.decide) begin
                shift_cnt_reg <= eff_count;
                if (!too_long_reg && long_count) begin
                    pre_reg <= !pre_reg;
                    if (!pre_reg) begin
                        pol_reg <= !level_reg;
                    end
                end
            end
            if (cmd.shift) begin
                // Oldest bit sits at index 0, the newest enters at the top.
                frame_reg     <= {level_reg ^ pol_reg, frame_reg[FRAME_BITS-1:1]};
                shift_cnt_reg <= shift_cnt_reg - 1'b1;
            end
            if (cmd.check) begin
                match_reg <= match_next;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            level_reg     <= in_level;
            too_long_reg  <= in_duration > DUR_W'(max_pulse);
            above_min_reg <= in_duration > DUR_W'(min_pulse);
            num_reg       <= NW'(in_duration[PULSE_W-1:0]) + NW'(BIT_PERIOD / 2);
        end else if (cmd.div_step) begin
            quo_reg <= NW'(prod >> SH);
        end
        if (cmd.check) begin
            card_reg <= card_next;
        end
        if (cmd.load_out) begin
            out_card_reg <= card_reg;
        end
    end

    assign st.skip       = (eff_count == '0);
    assign st.last_shift = (shift_cnt_reg == CNT_W'(1));
    assign st.match      = match_reg;
    assign st.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_card  = out_card_reg;

endmodule

### verif/tb_rfid_async_frame_decoder_top.sv
// Self-checking testbench for rfid_async_frame_decoder_top: drives level/duration words,
// predicts card numbers with its own frame decoder model and compares every output word.
// Depends on rfid_afd_pkg and the RTL of rfid_async_frame_decoder_top.
module tb_rfid_async_frame_decoder_top;
    import rfid_afd_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int DRAIN_CYCLES   = 200;
    localparam int TIMEOUT_CYCLES = 1500000;
    localparam int LIVE_TARGET    = 1750;
    localparam int CARD_TARGET    = 32;
    // Shortest and longest duration that round to nine bit periods.
    localparam int LONG_LO        = 9 * BIT_PERIOD_DEF - BIT_PERIOD_DEF / 2;
    localparam int LONG_HI        = 9 * BIT_PERIOD_DEF + BIT_PERIOD_DEF / 2 - 1;
    localparam bit [2:0] MIN_ADDR = {REG_MIN_PULSE, 2'b00};
    localparam bit [2:0] MAX_ADDR = {REG_MAX_PULSE, 2'b00};

    typedef enum int {SEQ_GOOD, SEQ_BAD_DIGIT, SEQ_FLIPPED, SEQ_CUT, SEQ_NOISE} seq_kind_t;

    typedef struct packed {
        bit        lvl;
        bit [15:0] dur;
        bit        quiet;
    } probe_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state.
    bit [FRAME_BITS-1:0] line_bits;
    bit                  pre_armed;
    bit                  inv_level;
    bit [PULSE_W-1:0]    cur_min;
    bit [PULSE_W-1:0]    cur_max;

    bit [31:0]   card_q[$];
    int unsigned fault_cnt;
    int unsigned sent_all;
    int unsigned sent_live;
    int unsigned cards_due;
    int unsigned seq_no;
    bit          gap_en;
    bit          stall_en;
    bit          quiet_tail;
    int unsigned hold_left;

    // Rows are typed as silent where that is plain: zero length, exactly
    // min_pulse, and durations beyond max_pulse.
    probe_t probes [0:14] = '{
        {1'b0, 16'd0,     1'b1},
        {1'b1, 16'd60,    1'b1},
        {1'b1, 16'd61,    1'b0},
        {1'b0, 16'd65535, 1'b1},
        {1'b1, 16'd4001,  1'b1},
        {1'b0, 16'd4000,  1'b0},
        {1'b1, 16'd127,   1'b0},
        {1'b0, 16'd128,   1'b0},
        {1'b1, 16'd383,   1'b0},
        {1'b0, 16'd384,   1'b0},
        {1'b1, 16'd2175,  1'b0},
        {1'b0, 16'd2176,  1'b0},
        {1'b1, 16'd2303,  1'b0},
        {1'b0, 16'd4095,  1'b1},
        {1'b1, 16'd32768, 1'b1}
    };

    rfid_async_frame_decoder_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #CLK_HALF;
        aclk = 1'b0;
        #CLK_HALF;
    end

    function automatic bit digit_value(input bit [6:0] c, output bit [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = c[3:0];
        end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            v = c[3:0] + 4'd9;
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one interval to the predictor state; returns 1 with the card number
    // when the frame register holds a complete, valid frame afterwards.
    function automatic bit decode_interval(input bit lvl, input bit [15:0] dur,
                                           output bit [31:0] card);
        int unsigned n;
        int          k;
        bit [7:0]    ch;
        bit [6:0]    xsum;
        bit [3:0]    nib;
        card = 32'd0;
        if (dur > cur_max) return 1'b0;
        n = (int'(dur) + BIT_PERIOD_DEF / 2) / BIT_PERIOD_DEF;
        if (n >= LONG_LIMIT && !pre_armed) begin
            n = PREAMBLE_BITS;
            pre_armed = 1'b1;
            inv_level = ~lvl;
        end else if (n >= LONG_LIMIT) begin
            pre_armed = 1'b0;
        end else if (n == 0 && dur > cur_min) begin
            n = 1;
        end
        if (n == 0) return 1'b0;
        if (n > FRAME_BITS) n = FRAME_BITS;
        repeat (n) line_bits = {lvl ^ inv_level, line_bits[FRAME_BITS-1:1]};

        if (line_bits[7:0] != MARK_BYTE) return 1'b0;
        if (line_bits[10:8] != 3'b100) return 1'b0;
        for (k = 0; k < 8; k++) begin
            if (line_bits[11 + k] != STX_BYTE[7 - k]) return 1'b0;
        end
        if (line_bits[FRAME_BITS-1 -: 8] != MARK_BYTE) return 1'b0;
        xsum = 7'd0;
        for (k = 0; k < NUM_CHARS; k++) begin
            ch = line_bits[CHAR_START + CHAR_LEN * k +: 8];
            if (^ch != 1'b1) return 1'b0;
            if (k < NUM_CHARS - 1) begin
                xsum ^= ch[6:0];
            end else if ((ch[6:0] & DATA_MASK) != xsum) begin
                return 1'b0;
            end
        end
        for (k = 0; k < NUM_CHARS - 1; k++) begin
            ch = line_bits[CHAR_START + CHAR_LEN * k +: 8];
            if (!digit_value(ch[6:0], nib)) return 1'b0;
            card = {card[27:0], nib};
        end
        return 1'b1;
    endfunction

    // Duration that counts as the given number of bit periods.
    function automatic bit [15:0] pick_duration(input int unsigned run);
        if (run == 1 && cur_min < 127 && $urandom_range(0, 3) == 0) begin
            return 16'($urandom_range(cur_min + 1, 127));
        end
        return 16'($urandom_range(run * BIT_PERIOD_DEF - BIT_PERIOD_DEF / 2,
                                  run * BIT_PERIOD_DEF + BIT_PERIOD_DEF / 2 - 1));
    endfunction

    function automatic bit [6:0] pick_digit(input bit want_hex);
        int unsigned r;
        bit [6:0]    c;
        bit [3:0]    nib;
        if (want_hex) begin
            r = $urandom_range(0, 21);
            if (r < 10) c = 7'("0" + r);
            else if (r < 16) c = 7'("A" + r - 10);
            else c = 7'("a" + r - 16);
        end else begin
            do c = 7'($urandom_range(0, 127)); while (digit_value(c, nib));
        end
        return c;
    endfunction

    // Presents one word and returns at the edge where it is taken.
    task automatic send_word(input bit lvl, input bit [15:0] dur, input bit quiet);
        bit [31:0] card;
        if (gap_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, dur, lvl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_all++;
        if (dur <= cur_max) sent_live++;
        if (decode_interval(lvl, dur, card) && !quiet) begin
            card_q.push_back(card);
            cards_due++;
        end
    endtask

    task automatic play_frame(input seq_kind_t kind);
        bit [FRAME_BITS-1:0] fb;
        bit [16:0]           pulse_q[$];
        bit [6:0]            dat;
        bit [6:0]            xsum;
        bit                  pol;
        bit                  lvl;
        int                  i;
        int                  k;
        int                  pos;
        int                  run;
        int                  keep;
        int                  bad_k;
        lvl   = 1'($urandom_range(0, 1));
        pol   = ~lvl;
        bad_k = (kind == SEQ_BAD_DIGIT) ? $urandom_range(0, NUM_CHARS - 2) : -1;
        // A pending preamble flag would swallow the start mark, so clear it first.
        if (pre_armed) pulse_q.push_back({1'($urandom_range(0, 1)),
                                          16'($urandom_range(LONG_LO, cur_max))});
        pulse_q.push_back({lvl, 16'($urandom_range(LONG_LO, cur_max))});

        fb = '0;
        fb[7:0]  = MARK_BYTE;
        fb[10:8] = 3'b100;
        for (i = 0; i < 8; i++) fb[11 + i] = STX_BYTE[7 - i];
        for (i = 19; i < CHAR_START; i++) fb[i] = 1'($urandom_range(0, 1));
        xsum = 7'd0;
        for (k = 0; k < NUM_CHARS; k++) begin
            pos = CHAR_START + CHAR_LEN * k;
            if (k == NUM_CHARS - 1) dat = xsum;
            else dat = pick_digit(k != bad_k);
            xsum ^= (k < NUM_CHARS - 1) ? dat : 7'd0;
            fb[pos +: 7]  = dat;
            fb[pos + 7]   = ~^dat;
            fb[pos + 8]   = 1'($urandom_range(0, 1));
            fb[pos + 9]   = 1'($urandom_range(0, 1));
        end
        fb[FRAME_BITS-1:127] = '1;
        if (kind == SEQ_FLIPPED) begin
            i = $urandom_range(8, 126);
            fb[i] = ~fb[i];
        end

        i = 8;
        while (i < 127) begin
            run = 1;
            while (i + run < 127 && run < PREAMBLE_BITS && fb[i + run] == fb[i]) run++;
            pulse_q.push_back({fb[i] ^ pol, pick_duration(run)});
            i += run;
        end
        // The closing mark is one long interval of nine ones, which also clears the flag.
        pulse_q.push_back({~pol, 16'($urandom_range(LONG_LO, LONG_HI))});

        keep = pulse_q.size();
        if (kind == SEQ_CUT) keep = $urandom_range(1, pulse_q.size() - 1);
        for (i = 0; i < keep; i++) send_word(pulse_q[i][16], pulse_q[i][15:0], 1'b0);
    endtask

    task automatic play_sequence();
        seq_kind_t kind;
        bit [15:0] dur;
        if (!quiet_tail) begin
            gap_en   = ($urandom_range(0, 3) != 0);
            stall_en = ($urandom_range(0, 3) != 0);
        end
        if (cur_max < LONG_HI) begin
            kind = SEQ_NOISE;
        end else if (seq_no == 0) begin
            kind = SEQ_GOOD;
        end else if (seq_no == 1) begin
            kind = SEQ_BAD_DIGIT;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: kind = SEQ_GOOD;
                6:                kind = SEQ_BAD_DIGIT;
                7:                kind = SEQ_FLIPPED;
                8:                kind = SEQ_CUT;
                default:          kind = SEQ_NOISE;
            endcase
        end
        seq_no++;
        if (kind != SEQ_NOISE) begin
            play_frame(kind);
        end else begin
            repeat ($urandom_range(5, 15)) begin
                case ($urandom_range(0, 3))
                    0:       dur = 16'($urandom_range(0, 255));
                    1:       dur = 16'($urandom_range(0, 4095));
                    2:       dur = 16'($urandom);
                    default: dur = 16'($urandom_range(LONG_LO, 4095));
                endcase
                send_word(1'($urandom_range(0, 1)), dur, 1'b0);
            end
        end
    endtask

    task automatic reg_write(input bit [2:0] addr, input bit [PULSE_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {20'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
    endtask

    task automatic reg_read(input bit [2:0] addr, input bit [PULSE_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {20'd0, want}) begin
            $display("%0t: register at 0x%0h reads wrong, expected %08h, got %08h",
                     $time, addr, {20'd0, want}, prdata);
            fault_cnt++;
        end
    endtask

    task automatic apply_config(input bit [PULSE_W-1:0] lo, input bit [PULSE_W-1:0] hi);
        reg_write(MIN_ADDR, lo);
        reg_write(MAX_ADDR, hi);
        cur_min = lo;
        cur_max = hi;
        reg_read(MIN_ADDR, lo);
        reg_read(MAX_ADDR, hi);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stops the sender, lets every predicted word arrive, then lets the block go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (card_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_en && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : card_check
        bit [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (card_q.size() == 0) begin
                $display("%0t: card number word not expected, expected none, got %08h",
                         $time, m_tdata);
                fault_cnt++;
            end else begin
                want = card_q.pop_front();
                if (m_tdata !== want) begin
                    $display("%0t: card number mismatch, expected %08h, got %08h",
                             $time, want, m_tdata);
                    fault_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        int          ph;
        int          i;
        int unsigned base;
        int unsigned budget;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 24'd0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 3'd0;
        pwdata   <= 32'd0;
        line_bits  = '0;
        pre_armed  = 1'b0;
        inv_level  = 1'b0;
        cur_min    = MIN_PULSE_RST;
        cur_max    = MAX_PULSE_RST;
        fault_cnt  = 0;
        sent_all   = 0;
        sent_live  = 0;
        cards_due  = 0;
        seq_no     = 0;
        gap_en     = 1'b1;
        stall_en   = 1'b1;
        quiet_tail = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < 15; i++) send_word(probes[i].lvl, probes[i].dur, probes[i].quiet);

        for (ph = 0; ph < 7; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1:       apply_config(12'd0, 12'd4095);
                    2:       apply_config(12'd4095, 12'd4095);
                    3:       apply_config(12'd0, 12'd0);
                    4:       apply_config(12'd127, 12'(LONG_HI));
                    5:       apply_config(12'($urandom_range(0, 300)),
                                          12'($urandom_range(LONG_HI, 4095)));
                    default: apply_config(MIN_PULSE_RST, MAX_PULSE_RST);
                endcase
            end
            base   = sent_all;
            budget = (ph == 3) ? 40 : 300;
            if (ph == 6) begin
                // Closing stretch runs at full rate on both sides.
                quiet_tail = 1'b1;
                gap_en     = 1'b0;
                stall_en   = 1'b0;
                while (sent_live < LIVE_TARGET || cards_due < CARD_TARGET) play_sequence();
            end else begin
                while (sent_all - base < budget) play_sequence();
            end
        end
        settle();

        if (fault_cnt == 0) begin
            $display("PASS rfid_async_frame_decoder_top");
        end else begin
            $display("FAIL rfid_async_frame_decoder_top");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("FAIL rfid_async_frame_decoder_top");
        $finish;
    end

endmodule
